// ===== sv/bounded_ordered_list_engine_defines.svh =====
// Assertion macros shared by the checker of the bounded ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define BOLE_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bounded ordered list engine check failed");

// A condition that must hold on every valid result word.
`define BOLE_CHECK_OUT(label, expr) \
    `BOLE_CHECK(label, m_tvalid |-> (expr))

`endif

// ===== sv/bole_pkg.sv =====
// Types and codes shared by the bounded ordered list engine modules.
package bole_pkg;

    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] stat_t;
    typedef logic [2:0]        cmd_t;

    localparam func_t OP_APPEND       = 3'd0;
    localparam func_t OP_INSERT_HEAD  = 3'd1;
    localparam func_t OP_REMOVE_HEAD  = 3'd2;
    localparam func_t OP_SEARCH       = 3'd3;
    localparam func_t OP_REMOVE_VALUE = 3'd4;

    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_EMPTY = 2'd1;
    localparam stat_t STAT_FULL  = 2'd2;

    // Commands broadcast from the controller to every cell.
    localparam cmd_t CMD_IDLE   = 3'd0;
    localparam cmd_t CMD_APPEND = 3'd1;
    localparam cmd_t CMD_INSERT = 3'd2;
    localparam cmd_t CMD_POP    = 3'd3;
    localparam cmd_t CMD_START  = 3'd4;
    localparam cmd_t CMD_STEP   = 3'd5;
    localparam cmd_t CMD_DROP   = 3'd6;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [VALUE_W-1:0] value;
    } ctl_t;

endpackage

// ===== sv/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: a row of list cells and its controller.
//
// The list lives in a row of CAPACITY cells, head in cell 0; every shift moves each
// entry it covers one cell at once. Append, insert head, remove head and unused codes
// finish in the request cycle, and their result word is registered in the output
// register, or in the second buffer slot while the output stalls, so these run at one
// word per cycle while results drain. Search and remove value pass a marker down the
// row one cell per cycle after the request cycle until it finds a match or passes the
// last occupied entry, and no new request is taken during that scan. A two-deep result
// buffer keeps the request side open while one result waits.
module bounded_ordered_list_engine #(
    parameter int CAPACITY = 16,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int OUT_W   = ((bole_pkg::VALUE_W + 1 + bole_pkg::STAT_W + CNT_W + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bole_pkg::VALUE_W-1:0] s_tdata,  // value
    input  logic [bole_pkg::FUNC_W-1:0]  s_tuser,  // func
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [OUT_W-1:0]             m_tdata   // value_out, found, status, entry_count
);

    bole_pkg::ctl_t                      ctl;
    logic [CNT_W-1:0]                    count;
    logic signed [bole_pkg::VALUE_W-1:0] entry_vec [CAPACITY];
    logic [CAPACITY-1:0]                 pend_vec;
    logic [CAPACITY-1:0]                 hit_vec;
    logic [CAPACITY-1:0]                 live_vec;
    logic signed [bole_pkg::VALUE_W-1:0] value_out;
    logic                                found;
    bole_pkg::stat_t                     status;
    logic [CNT_W-1:0]                    entry_count;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [bole_pkg::VALUE_W-1:0] left_entry;
            logic signed [bole_pkg::VALUE_W-1:0] right_entry;
            logic                                left_pend;

            if (i == 0)
            begin : g_head
                // The head takes the new value on insert head.
                assign left_entry = ctl.value;
                assign left_pend  = 1'b0;
            end
            else
            begin : g_body
                assign left_entry = entry_vec[i-1];
                assign left_pend  = pend_vec[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = entry_vec[i+1];
            end

            bole_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .count       (count),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .left_pend   (left_pend),
                .entry       (entry_vec[i]),
                .pend        (pend_vec[i]),
                .hit         (hit_vec[i]),
                .live        (live_vec[i])
            );
        end
    endgenerate

    bole_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_value   (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (value_out),
        .out_found  (found),
        .out_status (status),
        .out_count  (entry_count),
        .ctl        (ctl),
        .count      (count),
        .head_entry (entry_vec[0]),
        .hit_any    (|hit_vec),
        .live_any   (|live_vec)
    );

    assign m_tdata = OUT_W'({entry_count, status, found, value_out});

endmodule

// ===== sv/bole_cell.sv =====
// One list position: holds an entry and the scan marker, shifts to either neighbor.
module bole_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bole_pkg::ctl_t                    ctl,
    input  logic [CNT_W-1:0]                  count,
    input  logic signed [bole_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [bole_pkg::VALUE_W-1:0] right_entry,
    input  logic                              left_pend,
    output logic signed [bole_pkg::VALUE_W-1:0] entry,
    output logic                              pend,
    output logic                              hit,
    output logic                              live
);

    logic signed [bole_pkg::VALUE_W-1:0] entry_reg;
    logic signed [bole_pkg::VALUE_W-1:0] entry_next;
    logic                                pend_reg;
    logic                                pend_next;
    logic                                occupied;
    logic                                current;

    assign occupied = CNT_W'(IDX) < count;
    // The scan marker sits on the first cell that has not been passed yet.
    assign current  = pend_reg && !left_pend;
    assign live     = current && occupied;
    assign hit      = live && (entry_reg == ctl.value);
    assign entry    = entry_reg;
    assign pend     = pend_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.cmd)
            bole_pkg::CMD_APPEND:
            begin
                if (CNT_W'(IDX) == count)
                begin
                    entry_next = ctl.value;
                end
            end
            bole_pkg::CMD_INSERT: entry_next = left_entry;
            bole_pkg::CMD_POP:    entry_next = right_entry;
            bole_pkg::CMD_DROP:
            begin
                // Cells from the match onward close the gap.
                if (pend_reg)
                begin
                    entry_next = right_entry;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.cmd)
            bole_pkg::CMD_START: pend_next = 1'b1;
            bole_pkg::CMD_STEP:  pend_next = pend_reg && left_pend;
            default:             pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== sv/bole_ctrl.sv =====
// Request decoder, scan sequencer, entry count and two-deep result buffer.
module bole_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bole_pkg::func_t                     in_func,
    input  logic signed [bole_pkg::VALUE_W-1:0] in_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bole_pkg::VALUE_W-1:0] out_value,
    output logic                                out_found,
    output bole_pkg::stat_t                     out_status,
    output logic [CNT_W-1:0]                    out_count,
    output bole_pkg::ctl_t                      ctl,
    output logic [CNT_W-1:0]                    count,
    input  logic signed [bole_pkg::VALUE_W-1:0] head_entry,
    input  logic                                hit_any,
    input  logic                                live_any
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                                state_reg;
    logic                                state_next;
    bole_pkg::func_t                     op_reg;
    logic signed [bole_pkg::VALUE_W-1:0] target_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;

    logic                                ov_reg;
    logic signed [bole_pkg::VALUE_W-1:0] ovalue_reg;
    logic                                ofound_reg;
    bole_pkg::stat_t                     ostatus_reg;
    logic [CNT_W-1:0]                    ocount_reg;

    logic                                pv_reg;
    logic signed [bole_pkg::VALUE_W-1:0] pvalue_reg;
    logic                                pfound_reg;
    bole_pkg::stat_t                     pstatus_reg;
    logic [CNT_W-1:0]                    pcount_reg;

    logic                                accept;
    logic                                full;
    logic                                empty;
    logic                                finish;
    logic signed [bole_pkg::VALUE_W-1:0] res_value;
    logic                                res_found;
    bole_pkg::stat_t                     res_status;
    logic                                out_free;

    assign full     = count_reg == CNT_W'(CAPACITY);
    assign empty    = count_reg == '0;
    assign in_ready = (state_reg == S_IDLE) && !pv_reg;
    assign accept   = in_valid && in_ready;
    assign count    = count_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        finish     = 1'b0;
        res_value  = '0;
        res_found  = 1'b0;
        res_status = bole_pkg::STAT_OK;
        ctl.cmd    = bole_pkg::CMD_IDLE;
        ctl.value  = accept ? in_value : target_reg;
        if (accept)
        begin
            case (in_func)
                bole_pkg::OP_APPEND, bole_pkg::OP_INSERT_HEAD:
                begin
                    finish = 1'b1;
                    if (full)
                    begin
                        res_status = bole_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ctl.cmd    = (in_func == bole_pkg::OP_APPEND) ?
                                     bole_pkg::CMD_APPEND : bole_pkg::CMD_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                bole_pkg::OP_REMOVE_HEAD:
                begin
                    finish = 1'b1;
                    if (empty)
                    begin
                        res_status = bole_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        ctl.cmd    = bole_pkg::CMD_POP;
                        res_value  = head_entry;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                bole_pkg::OP_SEARCH, bole_pkg::OP_REMOVE_VALUE:
                begin
                    ctl.cmd    = bole_pkg::CMD_START;
                    state_next = S_SCAN;
                end
                default: finish = 1'b1;
            endcase
        end
        else if (state_reg == S_SCAN)
        begin
            if (hit_any)
            begin
                finish     = 1'b1;
                res_found  = 1'b1;
                state_next = S_IDLE;
                if (op_reg == bole_pkg::OP_REMOVE_VALUE)
                begin
                    ctl.cmd    = bole_pkg::CMD_DROP;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            else if (!live_any)
            begin
                // The marker ran past the last occupied cell.
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                ctl.cmd = bole_pkg::CMD_STEP;
            end
        end
    end

    assign out_free = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_free)
            begin
                ov_reg <= pv_reg || finish;
                pv_reg <= 1'b0;
            end
            else if (finish)
            begin
                pv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_func;
            target_reg <= in_value;
        end
        if (out_free)
        begin
            if (pv_reg)
            begin
                ovalue_reg  <= pvalue_reg;
                ofound_reg  <= pfound_reg;
                ostatus_reg <= pstatus_reg;
                ocount_reg  <= pcount_reg;
            end
            else if (finish)
            begin
                ovalue_reg  <= res_value;
                ofound_reg  <= res_found;
                ostatus_reg <= res_status;
                ocount_reg  <= count_next;
            end
        end
        else if (finish)
        begin
            pvalue_reg  <= res_value;
            pfound_reg  <= res_found;
            pstatus_reg <= res_status;
            pcount_reg  <= count_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_value  = ovalue_reg;
    assign out_found  = ofound_reg;
    assign out_status = ostatus_reg;
    assign out_count  = ocount_reg;

endmodule

// ===== sv/bole_checker.sv =====
// Port-level checks on the result stream of the bounded ordered list engine.
`include "bounded_ordered_list_engine_defines.svh"

module bole_checker #(
    parameter int CAPACITY = 16,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int OUT_W   = ((bole_pkg::VALUE_W + 1 + bole_pkg::STAT_W + CNT_W + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int FOUND_B = bole_pkg::VALUE_W;
    localparam int STAT_LO = FOUND_B + 1;
    localparam int CNT_LO  = STAT_LO + bole_pkg::STAT_W;

    logic [bole_pkg::VALUE_W-1:0] value_out;
    logic                         found;
    bole_pkg::stat_t              status;
    logic [CNT_W-1:0]             entry_count;

    assign value_out   = m_tdata[bole_pkg::VALUE_W-1:0];
    assign found       = m_tdata[FOUND_B];
    assign status      = m_tdata[CNT_LO-1:STAT_LO];
    assign entry_count = m_tdata[CNT_LO+CNT_W-1:CNT_LO];

    // A refused remove head leaves an empty list and returns no value.
    `BOLE_CHECK_OUT(a_empty_result, status != bole_pkg::STAT_EMPTY || (entry_count == '0 && value_out == '0))
    // A full refusal reports a full list and never a match.
    `BOLE_CHECK_OUT(a_full_result, status != bole_pkg::STAT_FULL || (entry_count == CNT_W'(CAPACITY) && !found))
    // A match only comes from search or remove value, which return no value.
    `BOLE_CHECK_OUT(a_found_result, !found || (status == bole_pkg::STAT_OK && value_out == '0))
    // A stalled result word holds.
    `BOLE_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

endmodule

bind bounded_ordered_list_engine bole_checker #(.CAPACITY(CAPACITY)) u_bole_checker (.*);
